// File: hw/rtl/ecs_pkg.sv
// Shared types, codes and sizes for the event cue sequencer.
`default_nettype none

package ecs_pkg;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_SW = FIFO_AW + 1;
	localparam int NUM_SRC = 5;
	localparam int CFG_DW = 16;

	localparam logic [0:0] CFG_LOCK_DEBOUNCE = 1'd0;
	localparam logic [0:0] CFG_CUE_GAP = 1'd1;

	localparam logic [CFG_DW-1:0] LOCK_DEBOUNCE_RST = 16'd250;
	localparam logic [CFG_DW-1:0] CUE_GAP_RST = 16'd1200;

	localparam logic [3:0] ST_SAFE_IDLE = 4'd1;
	localparam logic [3:0] ST_LIFT_RAMP = 4'd2;
	localparam logic [3:0] ST_SPIN_HOLD = 4'd3;
	localparam logic [3:0] ST_STOPPING = 4'd4;
	localparam logic [3:0] ST_ROTATE_MOVING = 4'd5;
	localparam logic [3:0] ST_HARD_STOP = 4'd6;
	localparam logic [3:0] ST_FAULT_LATCHED = 4'd7;
	localparam logic [3:0] ST_RUN_OPENING = 4'd8;

	localparam logic [1:0] DOOR_CMD_CLOSE = 2'd1;
	localparam logic [1:0] DOOR_CMD_OPEN = 2'd2;

	localparam logic [3:0] KIND_MANUAL = 4'd0;
	localparam logic [3:0] KIND_POWER_ON = 4'd1;
	localparam logic [3:0] KIND_DOOR_CLOSING = 4'd2;
	localparam logic [3:0] KIND_DOOR_OPENING = 4'd3;
	localparam logic [3:0] KIND_LOCKING = 4'd4;
	localparam logic [3:0] KIND_UNLOCKING = 4'd5;
	localparam logic [3:0] KIND_SPINNING_UP = 4'd6;
	localparam logic [3:0] KIND_AT_SPEED = 4'd7;
	localparam logic [3:0] KIND_SLOWING = 4'd8;
	localparam logic [3:0] KIND_TUBE = 4'd9;
	localparam logic [3:0] KIND_FAULT = 4'd10;
	localparam logic [3:0] KIND_RUN_COMPLETE = 4'd11;

	localparam logic [3:0] TUBE_FIRST = 4'd1;
	localparam logic [3:0] TUBE_LAST = 4'd4;

	typedef logic [FIFO_AW-1:0] fifo_ptr_t;
	typedef logic [FIFO_CW-1:0] fifo_cnt_t;
	typedef logic [FIFO_SW-1:0] fifo_sum_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [3:0]  machine_state;
		logic [1:0]  door_command;
		logic        lock_commanded;
		logic        device_powered;
		logic [3:0]  target_tube;
		logic [7:0]  manual_clip;
	} tick_t;

	typedef struct packed {
		logic [3:0] cue_kind;
		logic [7:0] cue_arg;
	} cue_t;

endpackage

`default_nettype wire

// File: hw/rtl/event_cue_sequencer.sv
// Event cue sequencer top level: edge detection, cue queue and paced release.
`default_nettype none

// Usage: one machine snapshot per tick transfer on tick (tick_valid/tick_stall).
// Each snapshot is held in an input register; while it is held there the edge
// trackers, the cue queue and the release pacing are updated in one pass, and
// a released cue is placed in the output register cue (cue_valid/cue_stall).
// A cue therefore shows on cue_valid at the edge where its tick leaves the
// input register, and one tick is taken every cycle unless tick_stall is
// raised. A tick releases at most one cue; most ticks release none.
// The configuration registers (lock debounce and cue gap, in milliseconds)
// are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while no tick is in flight, which the block itself does not enforce.
// Reset clears the trackers, empties the queue and restores the default
// register values; the first tick after reset only records a baseline.
// When the receiver stalls with a cue waiting, ticks that release no cue
// still pass; a tick that would release one waits in the input register and
// tick_stall rises until the output register frees up.
module event_cue_sequencer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        tick_valid,
	output logic                             tick_stall,
	input  wire ecs_pkg::tick_t              tick,
	output logic                             cue_valid,
	input  wire logic                        cue_stall,
	output ecs_pkg::cue_t                    cue,
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [ecs_pkg::CFG_DW-1:0]  cfg_data
);

	logic [ecs_pkg::CFG_DW-1:0] debounce_q;
	logic [ecs_pkg::CFG_DW-1:0] gap_q;

	logic           s1_valid_q;
	ecs_pkg::tick_t tick_s1;

	logic        primed_q;
	logic        in_fault_q;
	logic [3:0]  prev_state_q;
	logic [1:0]  prev_door_q;
	logic        announced_lock_q;
	logic        lock_cand_q;
	logic [31:0] lock_time_q;
	logic        prev_powered_q;
	logic [31:0] last_release_q;

	ecs_pkg::cue_t       fifo_q [ecs_pkg::FIFO_DEPTH];
	ecs_pkg::fifo_ptr_t  head_q;
	ecs_pkg::fifo_cnt_t  count_q;

	ecs_pkg::cue_t       fifo_n [ecs_pkg::FIFO_DEPTH];
	ecs_pkg::fifo_ptr_t  head_n;
	ecs_pkg::fifo_cnt_t  count_n;

	logic                push_vld [ecs_pkg::NUM_SRC];
	ecs_pkg::cue_t       push_cue [ecs_pkg::NUM_SRC];

	logic        fault;
	logic        flush;
	logic        normal;
	logic        resync;
	logic        lock_cand_n;
	logic [31:0] lock_time_n;
	logic [31:0] lock_age;
	logic [31:0] gap_age;
	logic        announce;
	logic        pop;
	logic        advance;
	logic        out_free;

	assign fault = (tick_s1.machine_state == ecs_pkg::ST_HARD_STOP) ||
		(tick_s1.machine_state == ecs_pkg::ST_FAULT_LATCHED);
	assign flush = primed_q && (fault != in_fault_q);
	assign normal = primed_q && !fault && !in_fault_q;
	assign resync = !normal;

	assign lock_cand_n = tick_s1.lock_commanded;
	assign lock_time_n = (tick_s1.lock_commanded != lock_cand_q) ? tick_s1.now_ms : lock_time_q;
	assign lock_age = tick_s1.now_ms - lock_time_n;
	assign announce = (lock_cand_n != announced_lock_q) &&
		(lock_age >= {16'd0, debounce_q});
	assign gap_age = tick_s1.now_ms - last_release_q;

	always_comb begin
		for (int k = 0; k < ecs_pkg::NUM_SRC; k++) begin
			push_vld[k] = 1'b0;
			push_cue[k] = '0;
		end

		push_vld[0] = primed_q && !flush && (tick_s1.manual_clip != 8'd0);
		push_cue[0] = '{cue_kind: ecs_pkg::KIND_MANUAL, cue_arg: tick_s1.manual_clip};

		if (tick_s1.door_command != prev_door_q) begin
			if (tick_s1.door_command == ecs_pkg::DOOR_CMD_CLOSE) begin
				push_vld[1] = normal;
				push_cue[1].cue_kind = ecs_pkg::KIND_DOOR_CLOSING;
			end else if (tick_s1.door_command == ecs_pkg::DOOR_CMD_OPEN) begin
				push_vld[1] = normal;
				push_cue[1].cue_kind = ecs_pkg::KIND_DOOR_OPENING;
			end
		end

		push_vld[2] = normal && announce;
		push_cue[2].cue_kind = lock_cand_n ? ecs_pkg::KIND_LOCKING : ecs_pkg::KIND_UNLOCKING;

		push_vld[3] = normal && tick_s1.device_powered && !prev_powered_q;
		push_cue[3].cue_kind = ecs_pkg::KIND_POWER_ON;

		if (tick_s1.machine_state != prev_state_q) begin
			unique case (tick_s1.machine_state)
				ecs_pkg::ST_LIFT_RAMP: begin
					push_vld[4] = normal;
					push_cue[4].cue_kind = ecs_pkg::KIND_SPINNING_UP;
				end
				ecs_pkg::ST_SPIN_HOLD: begin
					push_vld[4] = normal;
					push_cue[4].cue_kind = ecs_pkg::KIND_AT_SPEED;
				end
				ecs_pkg::ST_STOPPING: begin
					push_vld[4] = normal;
					push_cue[4].cue_kind = ecs_pkg::KIND_SLOWING;
				end
				ecs_pkg::ST_ROTATE_MOVING: begin
					push_vld[4] = normal && (tick_s1.target_tube >= ecs_pkg::TUBE_FIRST) &&
						(tick_s1.target_tube <= ecs_pkg::TUBE_LAST);
					push_cue[4].cue_kind = ecs_pkg::KIND_TUBE;
					push_cue[4].cue_arg = {4'd0, tick_s1.target_tube};
				end
				ecs_pkg::ST_SAFE_IDLE: begin
					push_vld[4] = normal && (prev_state_q == ecs_pkg::ST_RUN_OPENING);
					push_cue[4].cue_kind = ecs_pkg::KIND_RUN_COMPLETE;
				end
				default: begin
					push_vld[4] = 1'b0;
				end
			endcase
		end
	end

	// Accepted cues fill consecutive slots behind the head; a full queue drops the rest.
	always_comb begin
		ecs_pkg::fifo_cnt_t cnt;
		ecs_pkg::fifo_sum_t sum;
		ecs_pkg::fifo_ptr_t slot;
		cnt = count_q;
		sum = '0;
		slot = '0;
		fifo_n = fifo_q;
		for (int k = 0; k < ecs_pkg::NUM_SRC; k++) begin
			if (push_vld[k] && (cnt < ecs_pkg::FIFO_CW'(ecs_pkg::FIFO_DEPTH))) begin
				sum = ecs_pkg::FIFO_SW'(head_q) + ecs_pkg::FIFO_SW'(cnt);
				if (sum >= ecs_pkg::FIFO_SW'(ecs_pkg::FIFO_DEPTH)) begin
					sum = sum - ecs_pkg::FIFO_SW'(ecs_pkg::FIFO_DEPTH);
				end
				slot = sum[ecs_pkg::FIFO_AW-1:0];
				fifo_n[slot] = push_cue[k];
				cnt = cnt + ecs_pkg::FIFO_CW'(1);
			end
		end

		pop = normal && (cnt != '0) && (gap_age >= {16'd0, gap_q});

		if (flush) begin
			head_n = '0;
			count_n = '0;
		end else if (pop) begin
			if (head_q == ecs_pkg::FIFO_AW'(ecs_pkg::FIFO_DEPTH - 1)) begin
				head_n = '0;
			end else begin
				head_n = head_q + ecs_pkg::FIFO_AW'(1);
			end
			count_n = cnt - ecs_pkg::FIFO_CW'(1);
		end else begin
			head_n = head_q;
			count_n = cnt;
		end
	end

	assign out_free = !cue_valid || !cue_stall;
	assign advance = s1_valid_q && (!pop || out_free);
	assign tick_stall = s1_valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= ecs_pkg::LOCK_DEBOUNCE_RST;
			gap_q <= ecs_pkg::CUE_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecs_pkg::CFG_LOCK_DEBOUNCE: debounce_q <= cfg_data;
				ecs_pkg::CFG_CUE_GAP:       gap_q <= cfg_data;
				default:                    gap_q <= gap_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!tick_stall) begin
			s1_valid_q <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			in_fault_q <= 1'b0;
			prev_state_q <= '0;
			prev_door_q <= '0;
			announced_lock_q <= 1'b0;
			lock_cand_q <= 1'b0;
			lock_time_q <= '0;
			prev_powered_q <= 1'b0;
			last_release_q <= '0;
			head_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			primed_q <= 1'b1;
			if (!primed_q || flush) begin
				in_fault_q <= fault;
			end
			prev_state_q <= tick_s1.machine_state;
			prev_door_q <= tick_s1.door_command;
			prev_powered_q <= tick_s1.device_powered;
			lock_cand_q <= lock_cand_n;
			if (resync) begin
				announced_lock_q <= tick_s1.lock_commanded;
				lock_time_q <= tick_s1.now_ms;
			end else begin
				lock_time_q <= lock_time_n;
				if (announce) begin
					announced_lock_q <= lock_cand_n;
				end
			end
			if (pop) begin
				last_release_q <= tick_s1.now_ms;
			end
			if (primed_q) begin
				head_q <= head_n;
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fifo_q <= fifo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cue_valid <= 1'b0;
		end else if (advance && pop) begin
			cue_valid <= 1'b1;
		end else if (!cue_stall) begin
			cue_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pop) begin
			cue <= fifo_n[head_q];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ecs_checker.sv
// Port-level assertions for the event cue sequencer, bound to the top level.
`default_nettype none

module ecs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        tick_valid,
	input wire logic                        tick_stall,
	input wire ecs_pkg::tick_t              tick,
	input wire logic                        cue_valid,
	input wire logic                        cue_stall,
	input wire ecs_pkg::cue_t               cue,
	input wire logic                        cfg_we,
	input wire logic [0:0]                  cfg_index,
	input wire logic [ecs_pkg::CFG_DW-1:0]  cfg_data
);

	logic unused_ok;
	assign unused_ok = tick_valid ^ tick_stall ^ (^tick) ^ cfg_we ^ cfg_index[0] ^ (^cfg_data);

	a_cue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cue_valid && cue_stall |=> cue_valid && $stable(cue))
		else $error("Stalled cue changed or was withdrawn.");

	a_no_fault_cue: assert property (@(posedge clk) disable iff (!arst_n)
		cue_valid |-> (cue.cue_kind != ecs_pkg::KIND_FAULT) &&
			(cue.cue_kind <= ecs_pkg::KIND_RUN_COMPLETE))
		else $error("Cue kind outside the released set.");

	a_arg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cue_valid && (cue.cue_kind != ecs_pkg::KIND_MANUAL) &&
			(cue.cue_kind != ecs_pkg::KIND_TUBE) |-> cue.cue_arg == 8'd0)
		else $error("Cue argument set on a kind that carries none.");

	a_tube_arg: assert property (@(posedge clk) disable iff (!arst_n)
		cue_valid && (cue.cue_kind == ecs_pkg::KIND_TUBE) |->
			(cue.cue_arg >= 8'd1) && (cue.cue_arg <= 8'd4))
		else $error("Tube cue carries an invalid tube number.");

	a_manual_arg: assert property (@(posedge clk) disable iff (!arst_n)
		cue_valid && (cue.cue_kind == ecs_pkg::KIND_MANUAL) |-> cue.cue_arg != 8'd0)
		else $error("Manual cue released without a clip number.");

endmodule

bind event_cue_sequencer ecs_checker u_ecs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick_valid),
	.tick_stall (tick_stall),
	.tick       (tick),
	.cue_valid  (cue_valid),
	.cue_stall  (cue_stall),
	.cue        (cue),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data)
);

`default_nettype wire
